>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the pulse counter bank.
// Stand-alone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> sv/qpcb_pkg.sv
// Shared types, constants and helpers for the qualified pulse counter bank.
// No dependencies.
`default_nettype none
package qpcb_pkg;

  localparam int PIN_W        = 16;
  localparam int COUNT_W      = 16;
  localparam int SLOTS_DEF    = 2;
  localparam int CHANNELS_DEF = 16;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_READ = 1'b1
  } qpcb_action_t;

  typedef struct packed {
    qpcb_action_t       action;
    logic [PIN_W-1:0]   pin_levels;
    logic               slot;
    logic [3:0]         channel;
  } qpcb_item_t;

  typedef struct packed {
    logic [PIN_W-1:0]   edge_mask;
    logic               ticked;
    logic [COUNT_W-1:0] count;
  } qpcb_result_t;

  // Bits of the pins that belong to an existing channel.
  function automatic logic [PIN_W-1:0] chan_mask(input int n);
    logic [PIN_W-1:0] m;
    m = '0;
    for (int c = 0; c < PIN_W; c++) begin
      if (c < n) m[c] = 1'b1;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

>>> sv/qualified_pulse_counter_bank.sv
// Qualified pulse counter bank: items pass stage 1, then the result register.
// Throughput one transaction per cycle unless the output stalls; rows are read at
// acceptance and written back from stage 1, bypassed for back-to-back ticks on one
// slot. Reset (synchronous, rst_n low) clears enable, the tick history, the row
// valid bits (so all counters read as zero) and both pipeline valid flags.
`default_nettype none
module qualified_pulse_counter_bank
  import qpcb_pkg::*;
#(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration write
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic               cfg_enable,
  // input transactions
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic               in_action,
  input  wire logic [PIN_W-1:0]   in_pin_levels,
  input  wire logic               in_slot,
  input  wire logic [3:0]         in_channel,
  // result transactions
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [PIN_W-1:0]   out_edge_mask,
  output      logic               out_ticked,
  output      logic [COUNT_W-1:0] out_count
);

  `include "assert_macros.svh"

  localparam int ROW_W = CHANNELS * COUNT_W;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // config register: must be written only while idle (a user rule, unchecked by the block); always ready
  logic enable_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_valid) begin
      enable_r <= cfg_enable;
    end
  end

  // stage 1: accepted transaction, row read in flight
  qpcb_item_t s1_item_r;
  logic       s1_valid_r;
  logic       s1_adv;
  logic       in_fire;

  // output register
  qpcb_result_t out_res_r;
  logic         out_valid_r;

  qpcb_result_t     s1_res;
  logic             row_we;
  logic [ROW_W-1:0] row_rd;
  logic [ROW_W-1:0] row_wr;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;

  // stage 1 moves on whenever the output register is free or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // out-of-range slots read row zero; the result is masked in the tick unit
  assign rd_addr = (32'(in_slot) < SLOTS) ? AW'(in_slot) : '0;
  assign wr_addr = AW'(s1_item_r.slot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.action     <= qpcb_action_t'(in_action);
      s1_item_r.pin_levels <= in_pin_levels;
      s1_item_r.slot       <= in_slot;
      s1_item_r.channel    <= in_channel;
    end
  end

  qpcb_count_mem #(
    .ROWS  (SLOTS),
    .ROW_W (ROW_W),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (row_rd),
    .wr_en   (row_we),
    .wr_addr (wr_addr),
    .wr_data (row_wr)
  );

  qpcb_tick_unit #(
    .SLOTS    (SLOTS),
    .CHANNELS (CHANNELS),
    .ROW_W    (ROW_W)
  ) u_tick (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (s1_item_r),
    .enable (enable_r),
    .fire   (s1_adv),
    .row_rd (row_rd),
    .res    (s1_res),
    .row_we (row_we),
    .row_wr (row_wr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) out_res_r <= s1_res;
  end

  assign out_valid     = out_valid_r;
  assign out_edge_mask = out_res_r.edge_mask;
  assign out_ticked    = out_res_r.ticked;
  assign out_count     = out_res_r.count;

  // an accepted transaction always lands in stage 1
  `ASSERT_NEXT(a_fire_fills_s1, clk, rst_n, in_fire, s1_valid_r)
  // an edge mask only comes with a processed tick
  `ASSERT_IMPLIES(a_edge_needs_tick, clk, rst_n,
    out_valid_r && (out_edge_mask != '0), out_ticked)
  // a tick result never carries a count
  `ASSERT_IMPLIES(a_tick_no_count, clk, rst_n,
    out_valid_r && out_ticked, out_count == '0)
  // counters are only written on enabled ticks
  `ASSERT_IMPLIES(a_write_needs_enable, clk, rst_n, row_we, enable_r && s1_adv)

endmodule
`default_nettype wire

>>> sv/qpcb_count_mem.sv
// Counter row store: one row of packed channel counters per time slot.
// Valid bits make unwritten rows read as zero after reset. Uses qpcb_pkg.
`default_nettype none
module qpcb_count_mem
  import qpcb_pkg::*;
#(
  parameter int ROWS  = SLOTS_DEF,
  parameter int ROW_W = CHANNELS_DEF * COUNT_W,
  parameter int AW    = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output      logic [ROW_W-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [ROW_W-1:0] wr_data
);

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROWS-1:0]  row_vld_r;
  logic [ROW_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  // write-through bypass when the same row is written in this cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) rd_data_r <= wr_data;
      else if (row_vld_r[rd_addr])      rd_data_r <= mem[rd_addr];
      else                              rd_data_r <= '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> sv/qpcb_tick_unit.sv
// Edge qualification, counter increment and read selection for one item.
// Holds the three-tick inactive history. Uses qpcb_pkg.
`default_nettype none
module qpcb_tick_unit
  import qpcb_pkg::*;
#(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int ROW_W    = CHANNELS * COUNT_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire qpcb_item_t       item,
  input  wire logic             enable,
  input  wire logic             fire,
  input  wire logic [ROW_W-1:0] row_rd,
  output      qpcb_result_t     res,
  output      logic             row_we,
  output      logic [ROW_W-1:0] row_wr
);

  localparam logic [PIN_W-1:0] CH_MASK = chan_mask(CHANNELS);

  logic [PIN_W-1:0]    hist0_r, hist1_r, hist2_r;
  logic [PIN_W-1:0]    edge_bits;
  logic [CHANNELS-1:0] edge_lanes;
  logic                is_tick;
  logic                slot_ok;
  logic [COUNT_W-1:0]  sel_count;

  assign is_tick    = (item.action == ACT_TICK) && enable;
  assign slot_ok    = (32'(item.slot) < SLOTS);
  assign edge_bits  = ~item.pin_levels & hist0_r & hist1_r & hist2_r & CH_MASK;
  assign edge_lanes = CHANNELS'(edge_bits);

  always_comb begin
    row_wr    = row_rd;
    sel_count = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      row_wr[c*COUNT_W +: COUNT_W] = row_rd[c*COUNT_W +: COUNT_W]
                                     + COUNT_W'(edge_lanes[c]);
      if (32'(item.channel) == c) sel_count = row_rd[c*COUNT_W +: COUNT_W];
    end
  end

  always_comb begin
    res.edge_mask = is_tick ? edge_bits : '0;
    res.ticked    = is_tick;
    res.count     = ((item.action == ACT_READ) && slot_ok) ? sel_count : '0;
  end

  assign row_we = fire && is_tick && slot_ok;

  // history moves only on enabled ticks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist0_r <= '0;
      hist1_r <= '0;
      hist2_r <= '0;
    end else if (fire && is_tick) begin
      hist2_r <= hist1_r;
      hist1_r <= hist0_r;
      hist0_r <= item.pin_levels;
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for qualified_pulse_counter_bank: directed and random
// transactions, an internal pulse-count predictor, per-field result comparison.
// Depends on qpcb_pkg and the qualified_pulse_counter_bank RTL only.
`timescale 1ns / 100ps

module testbench;
  import qpcb_pkg::*;

  localparam int SETTLE_CYCLES = 4;    // result register loads after stage 1, which follows acceptance
  localparam int HOLD_CYCLES   = 48;   // long receiver hold-off, enough to back up the pipe
  localparam int STALL_LIMIT   = 4000; // cycles with no transaction before giving up
  localparam logic [PIN_W-1:0] PRESENT_CHANNELS =
    (CHANNELS_DEF >= PIN_W) ? '1 : PIN_W'((1 << CHANNELS_DEF) - 1);

  // Every block input starts at a known value.
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_enable = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_action = 1'b0;
  logic [PIN_W-1:0]   in_pin_levels = '0;
  logic               in_slot = 1'b0;
  logic [3:0]         in_channel = '0;
  logic               out_ready = 1'b0;
  logic               cfg_ready;
  logic               in_ready;
  logic               out_valid;
  logic [PIN_W-1:0]   out_edge_mask;
  logic               out_ticked;
  logic [COUNT_W-1:0] out_count;

  qualified_pulse_counter_bank #(
    .SLOTS    (SLOTS_DEF),
    .CHANNELS (CHANNELS_DEF)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_enable    (cfg_enable),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_pin_levels (in_pin_levels),
    .in_slot       (in_slot),
    .in_channel    (in_channel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_edge_mask (out_edge_mask),
    .out_ticked    (out_ticked),
    .out_count     (out_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Transactions waiting to be offered, and results still owed by the block.
  qpcb_item_t   stimulus_fifo[$];
  qpcb_result_t owed_results[$];

  // Predictor state: our own copy of the enable bit, tick history and counters.
  logic               model_enable = 1'b0;
  logic [PIN_W-1:0]   inactive_hist[3];
  logic [COUNT_W-1:0] tallies[SLOTS_DEF][CHANNELS_DEF];

  int   send_idle_pct = 8;
  int   recv_idle_pct = 76;
  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   mismatches = 0;

  // Works out the single result of one transaction and advances the predictor.
  // History holds raw pin levels, so a one bit there means the channel was idle.
  function automatic qpcb_result_t count_pulses(qpcb_item_t it);
    qpcb_result_t res;
    res = '0;
    if (it.action == ACT_READ) begin
      if (it.slot < SLOTS_DEF && it.channel < CHANNELS_DEF)
        res.count = tallies[it.slot][it.channel];
    end else if (model_enable) begin
      res.ticked    = 1'b1;
      res.edge_mask = ~it.pin_levels & inactive_hist[0] & inactive_hist[1] &
                      inactive_hist[2] & PRESENT_CHANNELS;
      // Out-of-range slot: history still moves, no counter does.
      if (it.slot < SLOTS_DEF) begin
        for (int c = 0; c < PIN_W; c++) begin
          if (res.edge_mask[c]) tallies[it.slot][c] = tallies[it.slot][c] + 1'b1;
        end
      end
      inactive_hist[2] = inactive_hist[1];
      inactive_hist[1] = inactive_hist[0];
      inactive_hist[0] = it.pin_levels;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: takes the next pending item once the previous one has gone, or
  // idles at random. Valid is held with a steady payload until accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_inputs
    qpcb_item_t next;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (stimulus_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next = stimulus_fifo.pop_front();
        in_valid      <= 1'b1;
        in_action     <= next.action;
        in_pin_levels <= next.pin_levels;
        in_slot       <= next.slot;
        in_channel    <= next.channel;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off when one is requested
  // (hold_go toggles), counted here so the sender keeps pushing meanwhile.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Input side of the monitor: predict on every accepted transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      inactive_hist = '{default: '0};
      tallies       = '{default: '{default: '0}};
    end else if (in_valid && in_ready) begin
      owed_results.push_back(count_pulses(qpcb_item_t'{qpcb_action_t'(in_action),
                                                       in_pin_levels, in_slot, in_channel}));
    end
  end

  // Result side: compare each accepted result with the oldest one owed.
  always @(posedge clk) begin : check_results
    qpcb_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing owed: edge_mask %h ticked %0d count %h",
                   $realtime, out_edge_mask, out_ticked, out_count);
      end else begin
        want = owed_results.pop_front();
        if (out_edge_mask !== want.edge_mask || out_ticked !== want.ticked ||
            out_count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch (exp/got) edge_mask %h/%h ticked %0d/%0d count %h/%h",
                     $realtime, want.edge_mask, out_edge_mask, want.ticked, out_ticked,
                     want.count, out_count);
        end
      end
    end
  end

  // Watchdog: too long without any transaction on any channel means a hang.
  // Results with nothing owed do not count as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) ||
        (out_valid && out_ready && owed_results.size() != 0) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void queue_item(qpcb_action_t act, logic [PIN_W-1:0] pins,
                                     logic slot, logic [3:0] chan);
    stimulus_fifo.push_back(qpcb_item_t'{act, pins, slot, chan});
  endfunction

  // Random mix: mostly ticks, with pin patterns ranging from uniform noise to
  // quiet ticks and single active channels, so qualified pulses keep turning up.
  function automatic void queue_random_items(int n);
    qpcb_item_t it;
    for (int i = 0; i < n; i++) begin
      it.action  = ($urandom_range(99) < 30) ? ACT_READ : ACT_TICK;
      it.slot    = 1'($urandom_range(1));
      it.channel = 4'($urandom_range(15));
      case ($urandom_range(4))
        0, 1:    it.pin_levels = PIN_W'($urandom);
        2:       it.pin_levels = ~PIN_W'($urandom & $urandom & $urandom);
        3:       it.pin_levels = '1;
        default: it.pin_levels = ~(PIN_W'(1) << $urandom_range(PIN_W - 1));
      endcase
      stimulus_fifo.push_back(it);
    end
  endfunction

  // Wait until nothing is queued, offered or owed; checked on the falling edge
  // so the clocked processes have all settled.
  task automatic drain();
    do @(negedge clk);
    while (stimulus_fifo.size() != 0 || in_valid || owed_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write, only ever issued with the block idle.
  task automatic write_enable(logic value);
    @(posedge clk);
    cfg_valid  <= 1'b1;
    cfg_enable <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid    <= 1'b0;
    model_enable = value;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Disabled after reset: reads see cleared counters, a tick does nothing.
    queue_item(ACT_READ, 16'hFFFF, 1'b0, 4'd0);
    queue_item(ACT_READ, 16'h0000, 1'b1, 4'd15);
    queue_item(ACT_TICK, 16'h0000, 1'b0, 4'd0);
    drain();

    // Three quiet ticks prime the history, then every channel pulses at once.
    write_enable(1'b1);
    queue_item(ACT_TICK, 16'hFFFF, 1'b0, 4'd0);
    queue_item(ACT_TICK, 16'hFFFF, 1'b1, 4'd0);
    queue_item(ACT_TICK, 16'hFFFF, 1'b0, 4'd0);
    queue_item(ACT_TICK, 16'h0000, 1'b0, 4'd0);
    queue_item(ACT_TICK, 16'h0000, 1'b1, 4'd0);   // still active: no new edge
    queue_item(ACT_READ, 16'h0000, 1'b0, 4'd0);
    queue_item(ACT_READ, 16'h0000, 1'b0, 4'd15);
    queue_item(ACT_READ, 16'h0000, 1'b1, 4'd7);
    queue_item(ACT_TICK, 16'hFFFF, 1'b1, 4'd0);
    queue_item(ACT_TICK, 16'hFFFF, 1'b1, 4'd0);
    queue_item(ACT_TICK, 16'hFFFF, 1'b1, 4'd0);
    queue_item(ACT_TICK, 16'h5555, 1'b1, 4'd0);   // odd channels pulse in slot one
    queue_item(ACT_READ, 16'h0000, 1'b1, 4'd15);
    queue_item(ACT_READ, 16'h0000, 1'b1, 4'd0);
    drain();

    // Disabled tick leaves history alone; reads still return stored counts.
    write_enable(1'b0);
    queue_item(ACT_TICK, 16'h0000, 1'b1, 4'd0);
    queue_item(ACT_READ, 16'h0000, 1'b1, 4'd1);
    drain();
    write_enable(1'b1);
    queue_item(ACT_TICK, 16'hAAAA, 1'b0, 4'd0);   // even channels pulse in slot zero
    queue_item(ACT_READ, 16'h0000, 1'b0, 4'd0);

    // Random part, receiver slow.
    queue_random_items(350);
    drain();

    // Sender slow; a disabled stretch, then enabled again.
    @(negedge clk);
    send_idle_pct = 76;
    recv_idle_pct = 8;
    write_enable(1'b0);
    queue_random_items(150);
    drain();
    write_enable(1'b1);
    queue_random_items(250);
    drain();

    // Full rate both sides, with a long receiver hold-off to fill the pipe,
    // then a pause for every owed result before the last batch.
    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_items(175);
    @(posedge clk);
    hold_go <= ~hold_go;
    drain();
    queue_random_items(175);
    drain();

    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

>>> qualified_pulse_counter_bank.f
+incdir+sv
sv/qpcb_pkg.sv
sv/qpcb_count_mem.sv
sv/qpcb_tick_unit.sv
sv/qualified_pulse_counter_bank.sv
tb/sv/testbench.sv
